// ===== src/sms_pkg.sv =====
package sms_pkg;

    localparam int WORD_W      = 32;
    localparam int IDX_IN_W    = 6;
    localparam int SIZE_W      = 7;
    localparam int MAX_DIM_DEF = 64;

    localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_walk_state;

    typedef struct packed {
        logic valid;
        logic found;
    } t_walk_res;

endpackage

// ===== src/sms_store.sv =====
module sms_store
    import sms_pkg::*;
#(
    parameter int ADDR_W = 2 * $clog2(MAX_DIM_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [2**ADDR_W];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sms_walk.sv =====
module sms_walk
    import sms_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SIZE_W-1:0]   i_n,
    input  logic                i_accept,
    input  logic                i_action,
    input  logic [IDX_IN_W-1:0] i_row_index,
    input  logic [IDX_IN_W-1:0] i_col_index,
    input  logic [WORD_W-1:0]   i_value,
    input  logic                i_out_free,
    output logic                o_busy,
    output t_walk_res           o_res
);

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int IDX_W = (DIM_W < SIZE_W) ? DIM_W : SIZE_W;

    t_walk_state       r_state, n_state;
    logic [IDX_W-1:0]  r_r, n_r;
    logic [IDX_W-1:0]  r_c, n_c;
    logic [SIZE_W-1:0] r_n, n_n;
    logic [WORD_W-1:0] r_val, n_val;
    logic              r_hit, n_hit;

    logic              w_acc_q;
    logic              w_we;
    logic [WORD_W-1:0] w_rdata;
    logic              w_eq;
    logic              w_lt;
    logic [SIZE_W:0]   w_c_inc;
    logic              w_c_end;
    logic              w_r_zero;

    assign w_acc_q  = i_accept && (i_action == ACT_QUERY);
    assign w_we     = i_accept && (i_action == ACT_WRITE)
                      && ({1'b0, i_row_index} < i_n) && ({1'b0, i_col_index} < i_n);
    assign w_eq     = (w_rdata == r_val);
    assign w_lt     = (w_rdata < r_val);
    assign w_c_inc  = (SIZE_W+1)'(r_c) + (SIZE_W+1)'(1);
    assign w_c_end  = (w_c_inc >= {1'b0, r_n});
    assign w_r_zero = (r_r == '0);

    sms_store #(
        .ADDR_W(2 * DIM_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr({DIM_W'(i_row_index), DIM_W'(i_col_index)}),
        .i_wdata(i_value),
        .i_raddr({DIM_W'(n_r), DIM_W'(n_c)}),
        .o_rdata(w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_q) begin
                    n_state = (i_n == '0) ? ST_EMIT : ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_eq || (w_lt && w_c_end) || (!w_lt && w_r_zero)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_r   = r_r;
        n_c   = r_c;
        n_n   = r_n;
        n_val = r_val;
        n_hit = r_hit;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_q) begin
                    n_n   = i_n;
                    n_val = i_value;
                    n_r   = IDX_W'(i_n - SIZE_W'(1));
                    n_c   = '0;
                    n_hit = 1'b0;
                end
            end
            ST_WALK: begin
                if (w_eq) begin
                    n_hit = 1'b1;
                end else if (w_lt) begin
                    if (!w_c_end) begin
                        n_c = r_c + IDX_W'(1);
                    end
                end else if (!w_r_zero) begin
                    n_r = r_r - IDX_W'(1);
                end
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res.valid = (r_state == ST_EMIT) && i_out_free;
    assign o_res.found = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r   <= n_r;
        r_c   <= n_c;
        r_n   <= n_n;
        r_val <= n_val;
        r_hit <= n_hit;
    end

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> (SIZE_W'(r_r) < r_n) && (SIZE_W'(r_c) < r_n))
        else $error("walk coordinates outside matrix in use");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && w_acc_q |=> r_state != ST_IDLE)
        else $error("accepted query did not start");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && !i_out_free |=> r_state == ST_EMIT)
        else $error("result dropped while output slot busy");

endmodule

// ===== src/sorted_matrix_search.sv =====
// sorted matrix staircase search
// input channel: i_in_valid / o_in_stall, word = action, row, column, value.
// action write loads one entry of the matrix; an entry whose row or column is at or
// beyond the size in use is dropped. writes give no result.
// action query walks the matrix from the bottom-left entry, one entry per cycle
// through the single read port of the entry memory, moving right on smaller and
// up on larger, and returns one found word on o_out_valid / i_out_stall.
// o_in_stall stays high for the whole walk and the next word is taken the cycle
// after the result is loaded into the output register.
// the user sets the size in use through i_cfg_we / i_cfg_data only while idle;
// the block itself does not enforce this. reset sets 64.
// reset (i_rst_n low, synchronous) clears the sequencer and the output valid
// and restores the size; matrix contents are undefined until written.
// a stalled result holds in the output register; a finished walk waits for the
// register to free before the block takes new words.
module sorted_matrix_search
    import sms_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SIZE_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_action,
    input  logic [IDX_IN_W-1:0] i_row_index,
    input  logic [IDX_IN_W-1:0] i_col_index,
    input  logic [WORD_W-1:0]   i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found
);

    logic [SIZE_W-1:0] r_size;
    logic              r_out_valid, n_out_valid;
    logic              r_found;

    logic [SIZE_W-1:0] w_n;
    logic              w_busy;
    logic              w_accept;
    logic              w_out_free;
    t_walk_res         w_res;

    assign w_n        = (32'(r_size) > 32'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r_size;
    assign w_accept   = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;

    sms_walk #(
        .MAX_DIM(MAX_DIM)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n        (w_n),
        .i_accept   (w_accept),
        .i_action   (i_action),
        .i_row_index(i_row_index),
        .i_col_index(i_col_index),
        .i_value    (i_value),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_res      (w_res)
    );

    always_comb begin
        priority if (w_res.valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_found <= w_res.found;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> !r_out_valid || !i_out_stall)
        else $error("result loaded over a waiting result");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled output word dropped");

    a_found_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_found))
        else $error("stalled output word changed");

endmodule
